[hdl/ubm_pkg.sv]
`default_nettype none
package ubm_pkg;

  localparam logic [7:0] HDR_BASE          = 8'hF8;
  localparam logic [7:0] KEY_ENTER_PRESS   = 8'h72;
  localparam logic [7:0] KEY_ENTER_RELEASE = 8'hF2;
  localparam logic [7:0] ASCII_CR          = 8'h0D;
  localparam logic [7:0] KEY_UP            = 8'h48;
  localparam logic [7:0] KEY_DOWN          = 8'h50;
  localparam logic [7:0] WINDOW_RESET      = 8'd10;
  localparam logic [3:0] MIN_REPORT_LEN    = 4'd3;
  localparam int         NUM_SLOTS         = 3;

  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_BURST  = 2'd2
  } kind_t;

  // One result item without its last flag.
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         header_byte;
    logic signed [7:0]  delta_x;
    logic signed [7:0]  delta_y;
    logic [7:0]         key_code;
    logic [7:0]         key_ascii;
    logic [15:0]        repeat_count;
  } result_t;

  typedef struct packed {
    logic [7:0] previous_buttons;
    logic [7:0] ticks_since_wheel;
  } state_t;

  // Slot order: key event, burst, packet.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]          mask;
    result_t [NUM_SLOTS-1:0]       res;
  } slots_t;

endpackage
`default_nettype wire

[hdl/ubm_in_if.sv]
`default_nettype none
interface ubm_in_if;
  logic              valid;
  logic              ready;
  logic              device_present;
  logic              transfer_ok;
  logic [3:0]        report_len;
  logic [7:0]        button_bits;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic signed [7:0] wheel_steps;

  modport source (output valid, device_present, transfer_ok, report_len, button_bits,
                  move_x, move_y, wheel_steps, input ready);
  modport sink   (input valid, device_present, transfer_ok, report_len, button_bits,
                  move_x, move_y, wheel_steps, output ready);
endinterface
`default_nettype wire

[hdl/ubm_out_if.sv]
`default_nettype none
interface ubm_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        header_byte;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic [7:0]        key_code;
  logic [7:0]        key_ascii;
  logic [15:0]       repeat_count;
  logic              last;

  modport source (output valid, kind, header_byte, delta_x, delta_y, key_code, key_ascii,
                  repeat_count, last, input ready);
  modport sink   (input valid, kind, header_byte, delta_x, delta_y, key_code, key_ascii,
                  repeat_count, last, output ready);
endinterface
`default_nettype wire

[hdl/ubm_xlate.sv]
`default_nettype none
module ubm_xlate import ubm_pkg::*; (
  input  wire logic              device_present,
  input  wire logic              transfer_ok,
  input  wire logic [3:0]        report_len,
  input  wire logic [7:0]        button_bits,
  input  wire logic signed [7:0] move_x,
  input  wire logic signed [7:0] move_y,
  input  wire logic signed [7:0] wheel_steps,
  input  wire logic [7:0]        window,
  input  wire state_t            state,
  output state_t                 state_next,
  output slots_t                 slots
);

  logic [7:0]  ticks_inc;
  logic        report_ok;
  logic        moved;
  logic        wheeled;
  logic        burst_ok;
  logic [8:0]  mult;
  logic [7:0]  mag;
  logic [16:0] product;
  logic [7:0]  prev;

  always_comb begin
    prev      = state.previous_buttons;
    ticks_inc = (state.ticks_since_wheel < window) ? state.ticks_since_wheel + 8'd1
                                                   : state.ticks_since_wheel;
    report_ok = device_present && transfer_ok && (report_len >= MIN_REPORT_LEN);
    moved     = (button_bits != prev) || (move_x != 8'sd0) || (move_y != 8'sd0);
    wheeled   = (report_len > MIN_REPORT_LEN) && (wheel_steps != 8'sd0);
    burst_ok  = ticks_inc <= window;
    // window - ticks + 1, only meaningful when burst_ok (range 1..255)
    mult      = {1'b0, window} + 9'd1 - {1'b0, ticks_inc};
    mag       = wheel_steps[7] ? 8'(-wheel_steps) : 8'(wheel_steps);
    product   = mult * mag;

    slots.mask[0] = report_ok && moved && (button_bits[2] != prev[2]);
    slots.mask[1] = report_ok && wheeled && burst_ok;
    slots.mask[2] = report_ok && moved;

    slots.res[0]              = '0;
    slots.res[0].kind         = KIND_KEY;
    slots.res[0].key_code     = button_bits[2] ? KEY_ENTER_PRESS : KEY_ENTER_RELEASE;
    slots.res[0].key_ascii    = ASCII_CR;

    slots.res[1]              = '0;
    slots.res[1].kind         = KIND_BURST;
    slots.res[1].key_code     = wheel_steps[7] ? KEY_DOWN : KEY_UP;
    slots.res[1].repeat_count = product[15:0];

    slots.res[2]              = '0;
    slots.res[2].kind         = KIND_PACKET;
    slots.res[2].header_byte  = HDR_BASE | {6'd0, button_bits[0], button_bits[1]};
    slots.res[2].delta_x      = move_x;
    slots.res[2].delta_y      = move_y;

    state_next = state;
    if (device_present) begin
      state_next.ticks_since_wheel = (report_ok && wheeled) ? 8'd0 : ticks_inc;
      if (report_ok && moved) begin
        state_next.previous_buttons = button_bits;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/ubm_result_queue.sv]
`default_nettype none
module ubm_result_queue import ubm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire slots_t slots_in,
  input  wire logic   load_req,
  output logic        can_load,
  ubm_out_if.source   result
);

  logic [NUM_SLOTS-1:0]    mask;
  result_t [NUM_SLOTS-1:0] ent;
  logic                    take;
  logic                    only_one;
  result_t                 sel;

  always_comb begin
    only_one = (mask & (mask - 1'b1)) == '0;
    take     = (mask != '0) && result.ready;
    can_load = (mask == '0) || (take && only_one);
    if (mask[0]) begin
      sel = ent[0];
    end else if (mask[1]) begin
      sel = ent[1];
    end else begin
      sel = ent[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (can_load && load_req) begin
      mask <= slots_in.mask;
    end else if (can_load) begin
      mask <= '0;
    end else if (take) begin
      mask <= mask & (mask - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_req) begin
      ent <= slots_in.res;
    end
  end

  assign result.valid        = mask != '0;
  assign result.kind         = sel.kind;
  assign result.header_byte  = sel.header_byte;
  assign result.delta_x      = sel.delta_x;
  assign result.delta_y      = sel.delta_y;
  assign result.key_code     = sel.key_code;
  assign result.key_ascii    = sel.key_ascii;
  assign result.repeat_count = sel.repeat_count;
  assign result.last         = only_one;

endmodule
`default_nettype wire

[hdl/usb_boot_mouse_to_ikbd_bridge.sv]
`default_nettype none
// Boot-protocol mouse report to IKBD event bridge. Each report item on
// "report" yields zero to three result items on "result", in the order:
// Enter key event on a middle-button edge, arrow-key burst for a nonzero
// wheel, then a three-byte mouse packet (header 0xF8 with left/right
// swapped) on a button change or a move. The final result of a report has
// last set; a report that gives nothing produces no output. Reports are
// taken one per cycle while each gives one result at most and the result
// side is ready; else the input side runs at the drain rate of the
// three-slot result register. A report passes the input register, then
// the result register, before its first result. cfg_we/cfg_wdata load
// the wheel acceleration window (reset 10); write it only while idle.
module usb_boot_mouse_to_ikbd_bridge import ubm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  ubm_in_if.sink          report,
  ubm_out_if.source       result
);

  // input register
  logic              in_valid;
  logic              in_present;
  logic              in_ok;
  logic [3:0]        in_len;
  logic [7:0]        in_buttons;
  logic signed [7:0] in_x;
  logic signed [7:0] in_y;
  logic signed [7:0] in_wheel;

  logic [7:0] window;
  state_t     state;
  state_t     state_next;
  slots_t     slots;
  logic       can_load;
  logic       advance;

  // item moves from input register into the result register
  assign advance      = in_valid && can_load;
  assign report.ready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (report.ready) begin
      in_valid <= report.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (report.ready && report.valid) begin
      in_present <= report.device_present;
      in_ok      <= report.transfer_ok;
      in_len     <= report.report_len;
      in_buttons <= report.button_bits;
      in_x       <= report.move_x;
      in_y       <= report.move_y;
      in_wheel   <= report.wheel_steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      state  <= '0;
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      // state advances exactly once per report, when it is translated
      if (advance) begin
        state <= state_next;
      end
    end
  end

  ubm_xlate u_xlate (
    .device_present (in_present),
    .transfer_ok    (in_ok),
    .report_len     (in_len),
    .button_bits    (in_buttons),
    .move_x         (in_x),
    .move_y         (in_y),
    .wheel_steps    (in_wheel),
    .window         (window),
    .state          (state),
    .state_next     (state_next),
    .slots          (slots)
  );

  ubm_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .slots_in (slots),
    .load_req (in_valid),
    .can_load (can_load),
    .result   (result)
  );

endmodule
`default_nettype wire

[hdl/ubm_checker.sv]
`default_nettype none
module ubm_checker import ubm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  header_byte,
  input wire logic [7:0]  key_code,
  input wire logic [7:0]  key_ascii,
  input wire logic [15:0] repeat_count,
  input wire logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(key_code)
      && $stable(repeat_count) && $stable(last))
    else $error("stalled result changed");

  // a key event is never last: its packet always follows
  a_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_KEY |-> key_ascii == ASCII_CR && repeat_count == 16'd0
      && (key_code == KEY_ENTER_PRESS || key_code == KEY_ENTER_RELEASE) && !last)
    else $error("bad key event");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_BURST |-> repeat_count != 16'd0 && key_ascii == 8'd0
      && (key_code == KEY_UP || key_code == KEY_DOWN))
    else $error("bad arrow burst");

  // a packet is always the final result of its report
  a_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PACKET |-> last && header_byte[7:2] == HDR_BASE[7:2]
      && key_code == 8'd0)
    else $error("bad mouse packet");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind usb_boot_mouse_to_ikbd_bridge ubm_checker u_ubm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .kind         (result.kind),
  .header_byte  (result.header_byte),
  .key_code     (result.key_code),
  .key_ascii    (result.key_ascii),
  .repeat_count (result.repeat_count),
  .last         (result.last)
);
`default_nettype wire
